// ===== rtl/sbsi_pkg.sv =====
// sbsi_pkg: types, widths and register indexes for the segment/box slab test
// no dependencies
package sbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAG_W       = COORD_WIDTH + 1;
  localparam int T_W         = FRAC_BITS + 1;
  localparam int PROD_W      = MAG_W + T_W;
  localparam int CFG_IDX_W   = 3;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } seg_t;

  typedef struct packed {
    logic             hit;
    logic [T_W-1:0]   entry_t;
    coord_t           point_x;
    coord_t           point_y;
    coord_t           point_z;
  } res_t;

  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } box_t;

  // per-axis slab set-up carried alongside the dividers
  typedef struct packed {
    logic             reject;
    logic             need_st;
    logic             need_et;
    logic             neg;
    logic [MAG_W-1:0] num_st;
    logic [MAG_W-1:0] num_et;
    logic [MAG_W-1:0] mag;
    coord_t           s;
  } axis_t;

endpackage

// ===== rtl/sbsi_setup.sv =====
// sbsi_setup: first stage, per-axis slab compares, numerators and denominator
// depends on sbsi_pkg
module sbsi_setup (
  input  logic                    clk,
  input  logic                    en,
  input  sbsi_pkg::seg_t          seg,
  input  sbsi_pkg::box_t          box,
  output sbsi_pkg::axis_t [2:0]   axis_r
);

  sbsi_pkg::axis_t [2:0] axis_nxt;
  sbsi_pkg::coord_t [2:0] s_v, e_v;

  assign s_v = {seg.start_z, seg.start_y, seg.start_x};
  assign e_v = {seg.end_z, seg.end_y, seg.end_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [sbsi_pkg::MAG_W-1:0] s, e, lo, hi;
      logic rising;
      s  = {s_v[i][sbsi_pkg::COORD_WIDTH-1], s_v[i]};
      e  = {e_v[i][sbsi_pkg::COORD_WIDTH-1], e_v[i]};
      lo = {box.lo[i][sbsi_pkg::COORD_WIDTH-1], box.lo[i]};
      hi = {box.hi[i][sbsi_pkg::COORD_WIDTH-1], box.hi[i]};
      rising = s < e;
      axis_nxt[i].s   = s_v[i];
      axis_nxt[i].neg = !rising;
      if (rising) begin
        axis_nxt[i].reject  = (s > hi) || (e < lo);
        axis_nxt[i].need_st = s < lo;
        axis_nxt[i].need_et = e > hi;
        axis_nxt[i].mag     = e - s;
        axis_nxt[i].num_st  = lo - s;
        axis_nxt[i].num_et  = hi - s;
      end else begin
        axis_nxt[i].reject  = (e > hi) || (s < lo);
        axis_nxt[i].need_st = s > hi;
        axis_nxt[i].need_et = e < lo;
        axis_nxt[i].mag     = s - e;
        axis_nxt[i].num_st  = s - hi;
        axis_nxt[i].num_et  = s - lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis_r <= axis_nxt;
    end
  end

endmodule

// ===== rtl/sbsi_frac_div.sv =====
// sbsi_frac_div: pipelined restoring divider, floor(num * 2^FRAC_BITS / den)
// one quotient bit per stage; depends on sbsi_pkg
module sbsi_frac_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sbsi_pkg::MAG_W-1:0]   num,
  input  logic [sbsi_pkg::MAG_W-1:0]   den,
  output logic [sbsi_pkg::T_W-1:0]     quot
);

  localparam int FB = sbsi_pkg::FRAC_BITS;
  localparam int MW = sbsi_pkg::MAG_W;

  logic [MW-1:0] rem_r [0:FB];
  logic [MW-1:0] den_r [0:FB];
  logic [FB-1:0] q_r   [0:FB];
  logic          one_r [0:FB];

  // numerator not below denominator saturates to 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      one_r[0] <= num >= den;
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [MW:0]   r2;
    logic [MW-1:0] rem_nxt;
    logic          bit_nxt;
    always_comb begin
      r2      = {rem_r[k-1], 1'b0};
      bit_nxt = r2 >= {1'b0, den_r[k-1]};
      rem_nxt = bit_nxt ? MW'(r2 - {1'b0, den_r[k-1]}) : r2[MW-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_r[k-1];
        q_r[k]   <= {q_r[k-1][FB-2:0], bit_nxt};
        one_r[k] <= one_r[k-1];
      end
    end
  end

  assign quot = one_r[FB] ? sbsi_pkg::T_ONE : {1'b0, q_r[FB]};

endmodule

// ===== rtl/sbsi_finish.sv =====
// sbsi_finish: interval merge, hit point multiply and final add (three stages)
// depends on sbsi_pkg
module sbsi_finish (
  input  logic                               clk,
  input  logic                               en,
  input  sbsi_pkg::axis_t [2:0]              axis,
  input  logic [2:0][sbsi_pkg::T_W-1:0]      st,
  input  logic [2:0][sbsi_pkg::T_W-1:0]      et,
  output sbsi_pkg::res_t                     res_r
);

  localparam int FB = sbsi_pkg::FRAC_BITS;
  localparam int TW = sbsi_pkg::T_W;
  localparam int PW = sbsi_pkg::PROD_W;

  logic                            hit_c_r, hit_m_r;
  logic [TW-1:0]                   t_c_r, t_m_r;
  sbsi_pkg::coord_t [2:0]          s_c_r, s_m_r;
  logic [2:0]                      neg_c_r, neg_m_r;
  logic [2:0][sbsi_pkg::MAG_W-1:0] mag_c_r;
  logic [2:0][PW-1:0]              prod_m_r;

  logic          hit_nxt;
  logic [TW-1:0] fst_nxt, fet_nxt;
  sbsi_pkg::res_t res_nxt;

  always_comb begin
    logic rej;
    logic [TW-1:0] sti, eti;
    fst_nxt = '0;
    fet_nxt = sbsi_pkg::T_ONE;
    rej     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sti = axis[i].need_st ? st[i] : '0;
      eti = axis[i].need_et ? et[i] : sbsi_pkg::T_ONE;
      if (sti > fst_nxt) fst_nxt = sti;
      if (eti < fet_nxt) fet_nxt = eti;
      rej = rej | axis[i].reject;
    end
    hit_nxt = !rej && !(fet_nxt < fst_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_c_r <= hit_nxt;
      t_c_r   <= fst_nxt;
      for (int i = 0; i < 3; i++) begin
        s_c_r[i]   <= axis[i].s;
        neg_c_r[i] <= axis[i].neg;
        mag_c_r[i] <= axis[i].mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_m_r <= hit_c_r;
      t_m_r   <= t_c_r;
      s_m_r   <= s_c_r;
      neg_m_r <= neg_c_r;
      for (int i = 0; i < 3; i++) begin
        prod_m_r[i] <= PW'(mag_c_r[i]) * PW'(t_c_r);
      end
    end
  end

  always_comb begin
    sbsi_pkg::coord_t [2:0] pt;
    sbsi_pkg::coord_t p;
    for (int i = 0; i < 3; i++) begin
      p     = sbsi_pkg::COORD_WIDTH'(prod_m_r[i] >> FB);
      pt[i] = neg_m_r[i] ? s_m_r[i] - p : s_m_r[i] + p;
      if (!hit_m_r) pt[i] = '0;
    end
    res_nxt.hit     = hit_m_r;
    res_nxt.entry_t = hit_m_r ? t_m_r : '0;
    res_nxt.point_x = pt[0];
    res_nxt.point_y = pt[1];
    res_nxt.point_z = pt[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/segment_box_slab_intersect.sv =====
// segment_box_slab_intersect: segment versus box slab test, fully pipelined,
// one segment per cycle while the output is not stalled; the depth is set by
// the six bit-per-stage quotient dividers. a stalled output freezes the pipe.
// rst_n (synchronous) clears valid bits and the box corners to zero.
// depends on sbsi_pkg, sbsi_setup, sbsi_frac_div, sbsi_finish
module segment_box_slab_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sbsi_pkg::seg_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sbsi_pkg::res_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  sbsi_pkg::coord_t                  cfg_data
);

  localparam int FB    = sbsi_pkg::FRAC_BITS;
  localparam int DEPTH = FB + 5;

  sbsi_pkg::box_t        box_r;
  logic [DEPTH-1:0]      vld_r;
  logic                  adv;
  sbsi_pkg::axis_t [2:0] axis_s;
  sbsi_pkg::axis_t [2:0] axis_d_r [0:FB];
  logic [2:0][sbsi_pkg::T_W-1:0] st_q, et_q;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[DEPTH-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbsi_pkg::REG_MIN_X: box_r.lo[0] <= cfg_data;
        sbsi_pkg::REG_MIN_Y: box_r.lo[1] <= cfg_data;
        sbsi_pkg::REG_MIN_Z: box_r.lo[2] <= cfg_data;
        sbsi_pkg::REG_MAX_X: box_r.hi[0] <= cfg_data;
        sbsi_pkg::REG_MAX_Y: box_r.hi[1] <= cfg_data;
        sbsi_pkg::REG_MAX_Z: box_r.hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  sbsi_setup u_setup (
    .clk    (clk),
    .en     (adv),
    .seg    (in_data),
    .box    (box_r),
    .axis_r (axis_s)
  );

  for (genvar i = 0; i < 3; i++) begin : g_axis
    sbsi_frac_div u_div_st (
      .clk  (clk),
      .en   (adv),
      .num  (axis_s[i].num_st),
      .den  (axis_s[i].mag),
      .quot (st_q[i])
    );
    sbsi_frac_div u_div_et (
      .clk  (clk),
      .en   (adv),
      .num  (axis_s[i].num_et),
      .den  (axis_s[i].mag),
      .quot (et_q[i])
    );
  end

  // set-up fields ride along with the quotients
  always_ff @(posedge clk) begin
    if (adv) begin
      axis_d_r[0] <= axis_s;
      for (int k = 1; k <= FB; k++) begin
        axis_d_r[k] <= axis_d_r[k-1];
      end
    end
  end

  sbsi_finish u_finish (
    .clk   (clk),
    .en    (adv),
    .axis  (axis_d_r[FB]),
    .st    (st_q),
    .et    (et_q),
    .res_r (out_data)
  );

endmodule

// ===== rtl/sbsi_checker.sv =====
// sbsi_checker: port-level assertions for segment_box_slab_intersect
// depends on sbsi_pkg; bound to the top level below
module sbsi_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input sbsi_pkg::res_t  out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.entry_t == '0 && out_data.point_x == '0
      && out_data.point_y == '0 && out_data.point_z == '0)
    else $error("miss result not cleared");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_t <= sbsi_pkg::T_ONE)
    else $error("entry parameter above one");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid result after reset");

endmodule

bind segment_box_slab_intersect sbsi_checker u_sbsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
